[hdl/tbjfe_pkg.sv]
// Package: codes, character constants and the key word lookup for the field extractor.
`default_nettype none
package tbjfe_pkg;

  localparam int unsigned ByteW = 8;

  // Result kinds
  localparam logic [1:0] KindField = 2'd0;
  localparam logic [1:0] KindEntry = 2'd1;
  localparam logic [1:0] KindStop  = 2'd2;

  // Field targets
  localparam logic [1:0] FieldHeadword   = 2'd0;
  localparam logic [1:0] FieldReading    = 2'd1;
  localparam logic [1:0] FieldDefinition = 2'd2;

  // Sub-scanner modes
  localparam logic [1:0] ModeScan  = 2'd0;
  localparam logic [1:0] ModeKey   = 2'd1;
  localparam logic [1:0] ModeColon = 2'd2;
  localparam logic [1:0] ModeQuote = 2'd3;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSqOpen    = 8'h5B;
  localparam logic [7:0] ChSqClose   = 8'h5D;
  localparam logic [7:0] ChCuOpen    = 8'h7B;
  localparam logic [7:0] ChCuClose   = 8'h7D;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;

  localparam logic [2:0] KeyLen = 3'd7;

  // Characters of the key "content"
  function automatic logic [7:0] key_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h63; // c
      3'd1:    ch = 8'h6F; // o
      3'd2:    ch = 8'h6E; // n
      3'd3:    ch = 8'h74; // t
      3'd4:    ch = 8'h65; // e
      3'd5:    ch = 8'h6E; // n
      3'd6:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChNewline) || (c == ChTab);
  endfunction

endpackage
`default_nettype wire

[hdl/tbjfe_if.sv]
// Interfaces: input byte channel and result channel with valid/ready handshake.
`default_nettype none
interface tbjfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_of_file;

  modport source (output valid, output in_byte, output last_of_file, input ready);
  modport sink   (input valid, input in_byte, input last_of_file, output ready);
endinterface

interface tbjfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] field_index;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output field_index, output data_byte,
                  input ready);
  modport sink   (input valid, input kind, input field_index, input data_byte,
                  output ready);
endinterface
`default_nettype wire

[hdl/term_bank_json_field_extractor_unit.sv]
// Term-bank JSON field extractor: byte-wise scanner with a registered result stage.
//
// Takes one byte of a term-bank JSON file per transaction and gives at most one
// result per byte: a field byte tagged headword/reading/definition, an entry-complete
// mark or a stop mark. All scanner state updates in the cycle the byte is taken and
// the result lands in a single output register, so a byte can be taken every cycle
// as long as that register is empty or is drained in the same cycle. in_i.ready drops
// only while a result sits there unclaimed. Nesting depths are DEPTH_BITS wide and
// saturate. After a stop, bytes are taken and dropped until the one flagged
// last_of_file, which returns all state to reset.
`default_nettype none
module term_bank_json_field_extractor_unit #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  tbjfe_in_if.sink       in_i,
  tbjfe_out_if.source    out_o
);

  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] Depth0   = DEPTH_BITS'(0);
  localparam logic [DEPTH_BITS-1:0] Depth1   = DEPTH_BITS'(1);
  localparam logic [DEPTH_BITS-1:0] Depth2   = DEPTH_BITS'(2);
  localparam logic [DEPTH_BITS-1:0] Depth3   = DEPTH_BITS'(3);

  // scanner state
  logic                  inside_string_q, inside_string_d;
  logic                  inside_struct_q, inside_struct_d;
  logic [DEPTH_BITS-1:0] square_depth_q, square_depth_d;
  logic [DEPTH_BITS-1:0] curly_depth_q, curly_depth_d;
  logic [1:0]            entry_counter_q, entry_counter_d;
  logic [1:0]            target_field_q, target_field_d;
  logic [7:0]            prev_byte_q, prev_byte_d;
  logic [1:0]            sub_mode_q, sub_mode_d;
  logic [2:0]            key_pos_q, key_pos_d;
  logic                  key_mismatch_q, key_mismatch_d;
  logic [7:0]            key_prev_q, key_prev_d;
  logic                  halted_q, halted_d;

  // result register
  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [1:0] out_field_q;
  logic [7:0] out_data_q;

  logic       in_fire;
  logic       out_fire;
  logic       do_scan;
  logic       res_valid;
  logic [1:0] res_kind;
  logic [1:0] res_field;
  logic [7:0] res_data;
  logic       str_next;
  logic [7:0] c;

  assign c        = in_i.in_byte;
  assign out_fire = out_valid_q && out_o.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    inside_string_d = inside_string_q;
    inside_struct_d = inside_struct_q;
    square_depth_d  = square_depth_q;
    curly_depth_d   = curly_depth_q;
    entry_counter_d = entry_counter_q;
    target_field_d  = target_field_q;
    prev_byte_d     = prev_byte_q;
    sub_mode_d      = sub_mode_q;
    key_pos_d       = key_pos_q;
    key_mismatch_d  = key_mismatch_q;
    key_prev_d      = key_prev_q;
    halted_d        = halted_q;
    do_scan         = 1'b0;
    res_valid       = 1'b0;
    res_kind        = tbjfe_pkg::KindField;
    res_field       = tbjfe_pkg::FieldHeadword;
    res_data        = 8'h00;
    str_next        = 1'b0;

    if (!halted_q) begin
      unique case (sub_mode_q)
        tbjfe_pkg::ModeKey: begin
          if (c == tbjfe_pkg::ChQuote && key_prev_q != tbjfe_pkg::ChBackslash) begin
            sub_mode_d = (!key_mismatch_q && key_pos_q == tbjfe_pkg::KeyLen) ?
                         tbjfe_pkg::ModeColon : tbjfe_pkg::ModeScan;
          end else begin
            if (!key_mismatch_q && key_pos_q < tbjfe_pkg::KeyLen &&
                c == tbjfe_pkg::key_char(key_pos_q)) begin
              key_pos_d = key_pos_q + 3'd1;
            end else begin
              key_mismatch_d = 1'b1;
            end
            key_prev_d = c;
          end
        end
        tbjfe_pkg::ModeColon: begin
          if (tbjfe_pkg::is_space(c)) begin
            sub_mode_d = sub_mode_q;
          end else if (c == tbjfe_pkg::ChColon) begin
            sub_mode_d = tbjfe_pkg::ModeQuote;
          end else begin
            sub_mode_d = tbjfe_pkg::ModeScan;
            do_scan    = 1'b1;
          end
        end
        tbjfe_pkg::ModeQuote: begin
          if (tbjfe_pkg::is_space(c)) begin
            sub_mode_d = sub_mode_q;
          end else if (c == tbjfe_pkg::ChQuote) begin
            inside_string_d = 1'b1;
            sub_mode_d      = tbjfe_pkg::ModeScan;
          end else begin
            sub_mode_d = tbjfe_pkg::ModeScan;
            do_scan    = 1'b1;
          end
        end
        default: do_scan = 1'b1;
      endcase
    end

    if (do_scan) begin
      if (c == tbjfe_pkg::ChQuote && prev_byte_q != tbjfe_pkg::ChBackslash) begin
        // quotes in later fields of an entry are ignored outright
        if (!((entry_counter_q == 2'd2 && square_depth_q < Depth3) ||
              entry_counter_q == 2'd3)) begin
          str_next        = !inside_string_q;
          inside_string_d = str_next;
          if (!str_next && entry_counter_q < 2'd2) begin
            entry_counter_d = entry_counter_q + 2'd1;
            target_field_d  = entry_counter_q + 2'd1;
          end
          if (str_next && inside_struct_q) begin
            inside_string_d = 1'b0;
            sub_mode_d      = tbjfe_pkg::ModeKey;
            key_pos_d       = 3'd0;
            key_mismatch_d  = 1'b0;
            key_prev_d      = 8'h00;
          end
        end
      end else begin
        prev_byte_d = c;
        if (inside_string_q) begin
          res_valid = 1'b1;
          res_field = target_field_q;
          res_data  = c;
        end else if (c == tbjfe_pkg::ChSqOpen) begin
          if (square_depth_q < DepthMax) square_depth_d = square_depth_q + Depth1;
        end else if (c == tbjfe_pkg::ChSqClose) begin
          square_depth_d = (square_depth_q > Depth0) ? square_depth_q - Depth1 : Depth0;
          if (square_depth_d == Depth2) begin
            if (entry_counter_q < 2'd3) entry_counter_d = entry_counter_q + 2'd1;
          end else if (square_depth_d == Depth1) begin
            res_valid       = 1'b1;
            res_kind        = tbjfe_pkg::KindEntry;
            entry_counter_d = 2'd0;
            target_field_d  = tbjfe_pkg::FieldHeadword;
          end else if (square_depth_d == Depth0) begin
            // stop: previous byte is left as it was
            halted_d    = 1'b1;
            prev_byte_d = prev_byte_q;
            res_valid   = 1'b1;
            res_kind    = tbjfe_pkg::KindStop;
          end
        end else if (c == tbjfe_pkg::ChCuOpen) begin
          if (curly_depth_q < DepthMax) curly_depth_d = curly_depth_q + Depth1;
          inside_struct_d = 1'b1;
        end else if (c == tbjfe_pkg::ChCuClose) begin
          curly_depth_d = (curly_depth_q > Depth0) ? curly_depth_q - Depth1 : Depth0;
          if (curly_depth_d == Depth1) begin
            res_valid = 1'b1;
            res_field = target_field_q;
            res_data  = tbjfe_pkg::ChNewline;
          end else if (curly_depth_d == Depth0) begin
            inside_struct_d = 1'b0;
          end
        end
      end
    end

    if (in_i.last_of_file) begin
      inside_string_d = 1'b0;
      inside_struct_d = 1'b0;
      square_depth_d  = Depth0;
      curly_depth_d   = Depth0;
      entry_counter_d = 2'd0;
      target_field_d  = tbjfe_pkg::FieldHeadword;
      prev_byte_d     = 8'h00;
      sub_mode_d      = tbjfe_pkg::ModeScan;
      key_pos_d       = 3'd0;
      key_mismatch_d  = 1'b0;
      key_prev_d      = 8'h00;
      halted_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_string_q <= 1'b0;
      inside_struct_q <= 1'b0;
      square_depth_q  <= Depth0;
      curly_depth_q   <= Depth0;
      entry_counter_q <= 2'd0;
      target_field_q  <= tbjfe_pkg::FieldHeadword;
      prev_byte_q     <= 8'h00;
      sub_mode_q      <= tbjfe_pkg::ModeScan;
      key_pos_q       <= 3'd0;
      key_mismatch_q  <= 1'b0;
      key_prev_q      <= 8'h00;
      halted_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        inside_string_q <= inside_string_d;
        inside_struct_q <= inside_struct_d;
        square_depth_q  <= square_depth_d;
        curly_depth_q   <= curly_depth_d;
        entry_counter_q <= entry_counter_d;
        target_field_q  <= target_field_d;
        prev_byte_q     <= prev_byte_d;
        sub_mode_q      <= sub_mode_d;
        key_pos_q       <= key_pos_d;
        key_mismatch_q  <= key_mismatch_d;
        key_prev_q      <= key_prev_d;
        halted_q        <= halted_d;
        out_valid_q     <= res_valid;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_kind_q  <= res_kind;
      out_field_q <= res_field;
      out_data_q  <= res_data;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.field_index = out_field_q;
  assign out_o.data_byte   = out_data_q;

  // once stopped, an accepted byte yields no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && halted_q |=> !out_valid_q)
    else $error("result produced while halted");

  // key reading and colon/quote expectation only happen outside a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_mode_q != tbjfe_pkg::ModeScan |-> !inside_string_q)
    else $error("sub-scanner active inside a string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_field_q <= entry_counter_q)
    else $error("target field ahead of entry counter");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q != tbjfe_pkg::KindField |->
      out_field_q == tbjfe_pkg::FieldHeadword && out_data_q == 8'h00)
    else $error("marker result carries field data");

endmodule
`default_nettype wire
